// ----- rtl/rcma_pkg.sv -----
// Shared types and constants for the range-checked moving average unit.
package rcma_pkg;

   localparam int SAMPLE_W            = 12;
   localparam int DEFAULT_WINDOW_SIZE = 8;
   localparam int CSR_ADDR_W          = 3;
   localparam int CSR_DATA_W          = 32;

   // register index, taken from paddr[2]
   localparam logic REG_LOW_LIMIT  = 1'b0;
   localparam logic REG_HIGH_LIMIT = 1'b1;

   localparam logic signed [SAMPLE_W-1:0] LOW_LIMIT_RESET  = -12'sd640;
   localparam logic signed [SAMPLE_W-1:0] HIGH_LIMIT_RESET = 12'sd960;

   // flips the sign bit to move between offset-binary and two's complement
   localparam logic [SAMPLE_W-1:0] SIGN_FLIP = 12'h800;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] low_limit;
      logic signed [SAMPLE_W-1:0] high_limit;
   } rcma_limits_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] average;
      logic                       changed;
      logic                       rejected;
   } rcma_result_type;

endpackage

// ----- rtl/rcma_csr.sv -----
// Limit registers behind the APB-style configuration port.
module rcma_csr
   import rcma_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output rcma_limits_type       limits
);

   rcma_limits_type limits_ff;
   logic            wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign limits = limits_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff.low_limit  <= LOW_LIMIT_RESET;
         limits_ff.high_limit <= HIGH_LIMIT_RESET;
      end else if (wr_en) begin
         case (paddr[2])
            REG_LOW_LIMIT:  limits_ff.low_limit  <= pwdata[SAMPLE_W-1:0];
            REG_HIGH_LIMIT: limits_ff.high_limit <= pwdata[SAMPLE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_LOW_LIMIT:  prdata = {{(CSR_DATA_W-SAMPLE_W){1'b0}}, limits_ff.low_limit};
         REG_HIGH_LIMIT: prdata = {{(CSR_DATA_W-SAMPLE_W){1'b0}}, limits_ff.high_limit};
         default:        prdata = '0;
      endcase
   end

endmodule

// ----- rtl/rcma_core.sv -----
// Range check, sample window, running sum and floor mean for one request.
module rcma_core
   import rcma_pkg::*;
#(
   parameter int WINDOW_SIZE = DEFAULT_WINDOW_SIZE
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       load,
   input  logic signed [SAMPLE_W-1:0] sample,
   input  rcma_limits_type            limits,
   output rcma_result_type            result
);

   localparam int LOG_N = $clog2(WINDOW_SIZE);
   localparam int SUM_W = SAMPLE_W + LOG_N;
   localparam int DIV_K = SUM_W + LOG_N;
   localparam int M_W   = SUM_W + 2;
   // ceil(2^K / N): exact floor division for every biased sum below 2^SUM_W
   localparam logic [M_W-1:0] RECIP =
      M_W'(((64'd1 << DIV_K) + WINDOW_SIZE - 1) / WINDOW_SIZE);
   localparam logic [SUM_W-1:0]        OFFSET = SUM_W'(2048 * WINDOW_SIZE);
   localparam logic signed [SUM_W-1:0] N_S    = SUM_W'(WINDOW_SIZE);

   logic signed [SAMPLE_W-1:0] window_ff [WINDOW_SIZE];
   logic signed [SUM_W-1:0]    sum_ff;
   logic signed [SUM_W-1:0]    sum_in;
   logic signed [SAMPLE_W-1:0] last_avg_ff;
   logic                       seen_ff;

   logic                       rejected;
   logic signed [SAMPLE_W-1:0] val;
   logic signed [SUM_W-1:0]    val_ext;
   logic signed [SUM_W-1:0]    fill_sum;
   logic signed [SUM_W-1:0]    shift_sum;
   logic [SUM_W-1:0]           biased;
   logic [SUM_W+M_W-1:0]       prod;
   logic [SAMPLE_W-1:0]        quot;
   logic signed [SAMPLE_W-1:0] avg;

   assign rejected = (sample < limits.low_limit) || (sample > limits.high_limit);

   always_comb begin
      if (!rejected) begin
         val = sample;
      end else if (seen_ff) begin
         val = last_avg_ff;
      end else begin
         val = '0;
      end
   end

   assign val_ext   = SUM_W'(val);
   assign fill_sum  = val_ext * N_S;
   assign shift_sum = sum_ff - SUM_W'(window_ff[0]) + val_ext;

   // bias the sum to non-negative, multiply by the reciprocal to divide, then remove the bias
   assign biased = shift_sum + OFFSET;
   assign prod   = (SUM_W+M_W)'(biased) * (SUM_W+M_W)'(RECIP);
   assign quot   = prod[DIV_K+SAMPLE_W-1:DIV_K];

   assign avg    = seen_ff ? $signed(quot ^ SIGN_FLIP) : val;
   assign sum_in = seen_ff ? shift_sum : fill_sum;

   assign result.average  = avg;
   assign result.changed  = !seen_ff || (avg != last_avg_ff);
   assign result.rejected = rejected;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
      end else if (load) begin
         seen_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         sum_ff      <= sum_in;
         last_avg_ff <= avg;
         if (seen_ff) begin
            for (int i = 0; i < WINDOW_SIZE - 1; i++) begin
               window_ff[i] <= window_ff[i+1];
            end
            window_ff[WINDOW_SIZE-1] <= val;
         end else begin
            for (int i = 0; i < WINDOW_SIZE; i++) begin
               window_ff[i] <= val;
            end
         end
      end
   end

endmodule

// ----- rtl/range_checked_moving_average_unit.sv -----
// Top level: request and result registers around the moving average core.
//
// Usage notes
//   Request channel: req_valid / req_stall / req_sample (signed, 1/16 degree).
//   Result channel:  rsp_valid / rsp_stall / rsp_average, rsp_changed,
//                    rsp_rejected. A request or result moves on a rising edge
//                    with valid high and stall low.
//   Configuration:   APB-style, low_limit at 0x0, high_limit at 0x4, write
//                    only while the unit is idle.
//   Path: a taken request passes through the input register, then the
//   result register; rsp_valid rises as it enters the result register.
//   Throughput: one request per cycle while rsp_stall holds no waiting
//   result; the running sum and sample window update in the single
//   compute stage, and the mean is one constant reciprocal multiply.
//   Reset (synchronous): both stages empty, limits back to -40 and 60 degrees,
//   and the next request refills the whole window.
//   Stall: while rsp_stall holds a waiting result, one more request is still
//   taken into the input register; req_stall rises only when both are full.
module range_checked_moving_average_unit
   import rcma_pkg::*;
#(
   parameter int WINDOW_SIZE = DEFAULT_WINDOW_SIZE
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0] rsp_average,
   output logic                       rsp_changed,
   output logic                       rsp_rejected,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [CSR_ADDR_W-1:0]      paddr,
   input  logic [CSR_DATA_W-1:0]      pwdata,
   output logic [CSR_DATA_W-1:0]      prdata,
   output logic                       pready
);

   logic                       in_valid_ff;
   logic signed [SAMPLE_W-1:0] in_sample_ff;
   logic                       out_valid_ff;
   rcma_result_type            out_result_ff;
   rcma_result_type            core_result;
   rcma_limits_type            limits;
   logic                       advance;
   logic                       load;

   assign advance   = !out_valid_ff || !rsp_stall;
   assign load      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   rcma_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .limits  (limits)
   );

   rcma_core #(
      .WINDOW_SIZE (WINDOW_SIZE)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .load   (load),
      .sample (in_sample_ff),
      .limits (limits),
      .result (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_sample_ff <= req_sample;
      end
      if (load) begin
         out_result_ff <= core_result;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_average  = out_result_ff.average;
   assign rsp_changed  = out_result_ff.changed;
   assign rsp_rejected = out_result_ff.rejected;

`ifndef SYNTH
   // back-pressure only when both stages hold a request
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && out_valid_ff && rsp_stall))
      else $error("request stalled with a free stage");

   // a request leaving the input register always lands in the result register
   a_load_lands: assert property (@(posedge clock) disable iff (reset)
      load |=> out_valid_ff)
      else $error("computed request lost");

   // a taken result with nothing behind it empties the output
   a_drain: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !in_valid_ff) |=> !out_valid_ff)
      else $error("result repeated");

   // nothing is presented in the first cycle out of reset
   a_idle_after_reset: assert property (@(posedge clock) disable iff (reset)
      ($past(reset) && !reset && !in_valid_ff) |-> !out_valid_ff)
      else $error("result present straight after reset");
`endif

endmodule

// ----- dv/testbench.sv -----
// Testbench for the moving average unit: directed and random requests against a predictor.
`timescale 1ns / 1ps

module testbench;
   import rcma_pkg::*;

   localparam int DEPTH       = DEFAULT_WINDOW_SIZE;
   localparam int CYCLE_LIMIT = 300000;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic signed [SAMPLE_W-1:0] req_sample = '0;
   logic                       rsp_valid;
   wire                        rsp_stall;
   logic signed [SAMPLE_W-1:0] rsp_average;
   logic                       rsp_changed;
   logic                       rsp_rejected;
   logic                       psel = 1'b0;
   logic                       penable = 1'b0;
   logic                       pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0]      paddr = '0;
   logic [CSR_DATA_W-1:0]      pwdata = '0;
   logic [CSR_DATA_W-1:0]      prdata;
   logic                       pready;

   // predictor state
   logic signed [SAMPLE_W-1:0] lim_low  = LOW_LIMIT_RESET;
   logic signed [SAMPLE_W-1:0] lim_high = HIGH_LIMIT_RESET;
   logic signed [SAMPLE_W-1:0] win_taps [DEPTH];
   int                         win_sum = 0;
   logic signed [SAMPLE_W-1:0] prev_average = '0;
   bit                         window_primed = 1'b0;
   rcma_result_type            pending_averages[$];

   int   mismatches    = 0;
   int   cycle_count   = 0;
   int   req_max_gap   = 14;
   int   rsp_max_wait  = 14;
   int   rsp_wait_left = 0;
   logic rsp_wait      = 1'b0;
   logic rsp_hold      = 1'b0;
   int   hold_cycles   = 0;
   event hold_start;

   range_checked_moving_average_unit dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_sample   (req_sample),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_average  (rsp_average),
      .rsp_changed  (rsp_changed),
      .rsp_rejected (rsp_rejected),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[range_checked_moving_average_unit] ERROR");
         $finish;
      end
   end

   function automatic void flag_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch: %s", msg);
   endfunction

   function automatic void predict_average(input logic signed [SAMPLE_W-1:0] raw);
      rcma_result_type            res;
      logic signed [SAMPLE_W-1:0] taken;
      int                         avg;
      res.rejected = (raw < lim_low) || (raw > lim_high);
      taken = raw;
      if (res.rejected)
         taken = window_primed ? prev_average : '0;
      if (!window_primed) begin
         foreach (win_taps[i]) win_taps[i] = taken;
         win_sum = int'(taken) * DEPTH;
         avg = int'(taken);
         res.changed = 1'b1;
         window_primed = 1'b1;
      end else begin
         win_sum = win_sum - int'(win_taps[0]) + int'(taken);
         for (int i = 0; i < DEPTH - 1; i++) win_taps[i] = win_taps[i+1];
         win_taps[DEPTH-1] = taken;
         // floor of the mean, towards minus infinity
         avg = (win_sum >= 0) ? win_sum / DEPTH : -((-win_sum + DEPTH - 1) / DEPTH);
         res.changed = (avg != int'(prev_average));
      end
      res.average = SAMPLE_W'(avg);
      prev_average = SAMPLE_W'(avg);
      pending_averages.push_back(res);
   endfunction

   always @(posedge clock) begin : check_results
      rcma_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_averages.size() == 0) begin
            flag_mismatch($sformatf("unexpected result, average %0d", rsp_average));
         end else begin
            want = pending_averages.pop_front();
            if (rsp_average !== want.average)
               flag_mismatch($sformatf("average expected %0d got %0d",
                                       want.average, rsp_average));
            if (rsp_changed !== want.changed)
               flag_mismatch($sformatf("changed expected %0b got %0b",
                                       want.changed, rsp_changed));
            if (rsp_rejected !== want.rejected)
               flag_mismatch($sformatf("rejected expected %0b got %0b",
                                       want.rejected, rsp_rejected));
         end
      end
   end

   // receiver: random wait after each result, plus the long hold-off below
   always @(posedge clock) begin
      if (reset)
         rsp_wait_left = 0;
      else if (rsp_valid && !rsp_stall)
         rsp_wait_left = $urandom_range(0, rsp_max_wait);
      else if (rsp_wait_left > 0)
         rsp_wait_left--;
      rsp_wait <= (rsp_wait_left > 0);
   end

   assign rsp_stall = rsp_wait | rsp_hold;

   initial begin
      forever begin
         @(hold_start);
         @(posedge clock);
         rsp_hold <= 1'b1;
         repeat (hold_cycles) @(posedge clock);
         rsp_hold <= 1'b0;
      end
   end

   task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
      int gap;
      gap = $urandom_range(0, req_max_gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= value;
      do @(posedge clock); while (req_stall);
      predict_average(value);
   endtask

   task automatic wait_drained;
      req_valid <= 1'b0;
      while (pending_averages.size() > 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // write a limit, then read it back
   task automatic program_limit(input logic reg_sel, input logic signed [SAMPLE_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_sel, 2'b00};
      pwdata  <= {{(CSR_DATA_W-SAMPLE_W){value[SAMPLE_W-1]}}, value};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (reg_sel == REG_LOW_LIMIT)
         lim_low = value;
      else
         lim_high = value;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[SAMPLE_W-1:0] !== value)
         flag_mismatch($sformatf("limit %0d read back %0d, wrote %0d",
                                 reg_sel, $signed(prdata[SAMPLE_W-1:0]), value));
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic signed [SAMPLE_W-1:0] draw_sample(
      input logic signed [SAMPLE_W-1:0] prev);
      int lo;
      int hi;
      lo = int'(lim_low);
      hi = int'(lim_high);
      case ($urandom_range(0, 7))
         0, 1: return SAMPLE_W'($urandom_range(0, 4095));
         2: return prev;
         3: return SAMPLE_W'(($urandom_range(0, 1) ? lo : hi) + $urandom_range(0, 2) - 1);
         default: begin
            if (lo <= hi)
               return SAMPLE_W'(lo + $urandom_range(0, hi - lo));
            return SAMPLE_W'($urandom_range(0, 4095));
         end
      endcase
   endfunction

   // default limits: rejection before the window is primed, limits inclusive
   task automatic test_reset_limits;
      send_sample(2047);
      send_sample(-640);
      send_sample(960);
      send_sample(-641);
      send_sample(961);
      send_sample(-2048);
      send_sample(0);
      wait_drained();
   endtask

   task automatic test_limit_extremes;
      program_limit(REG_LOW_LIMIT, -2048);
      program_limit(REG_HIGH_LIMIT, 2047);
      send_sample(-2048);
      send_sample(2047);
      send_sample(-1);
      send_sample(0);
      send_sample(12'h555);
      send_sample(12'hAAA);
      wait_drained();
   endtask

   // low above high rejects everything; equal limits pass one value only
   task automatic test_crossed_limits;
      program_limit(REG_LOW_LIMIT, 100);
      program_limit(REG_HIGH_LIMIT, -100);
      send_sample(0);
      send_sample(100);
      send_sample(-100);
      send_sample(2047);
      send_sample(-2048);
      wait_drained();
      program_limit(REG_LOW_LIMIT, 5);
      program_limit(REG_HIGH_LIMIT, 5);
      send_sample(5);
      send_sample(4);
      send_sample(6);
      send_sample(5);
      wait_drained();
   endtask

   // receiver holds off while requests keep coming, so the unit backs up
   task automatic test_backpressure;
      logic signed [SAMPLE_W-1:0] s;
      program_limit(REG_LOW_LIMIT, LOW_LIMIT_RESET);
      program_limit(REG_HIGH_LIMIT, HIGH_LIMIT_RESET);
      req_max_gap = 0;
      hold_cycles = 80;
      -> hold_start;
      s = '0;
      repeat (30) begin
         s = draw_sample(s);
         send_sample(s);
      end
      wait_drained();
      req_max_gap = 14;
   endtask

   task automatic test_random_phases;
      logic signed [SAMPLE_W-1:0] a;
      logic signed [SAMPLE_W-1:0] b;
      logic signed [SAMPLE_W-1:0] s;
      s = '0;
      for (int phase = 0; phase < 8; phase++) begin
         a = SAMPLE_W'($urandom_range(0, 4095));
         b = SAMPLE_W'($urandom_range(0, 4095));
         case (phase)
            0: begin a = -2048; b = 2047; end
            1: begin a = 2047;  b = -2048; end
            2: begin a = LOW_LIMIT_RESET; b = HIGH_LIMIT_RESET; end
            6: ;
            default: if (a > b) begin
               a = b;
               b = SAMPLE_W'(a + $urandom_range(0, 2047 - a));
            end
         endcase
         program_limit(REG_LOW_LIMIT, a);
         program_limit(REG_HIGH_LIMIT, b);
         req_max_gap  = (phase % 3 == 0) ? 0 : 14;
         rsp_max_wait = (phase % 2 == 0) ? 0 : 14;
         repeat (160) begin
            s = draw_sample(s);
            send_sample(s);
         end
         wait_drained();
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_limits();
      test_limit_extremes();
      test_crossed_limits();
      test_backpressure();
      test_random_phases();
      if (mismatches == 0 && pending_averages.size() == 0)
         $display("[range_checked_moving_average_unit] OK");
      else
         $display("[range_checked_moving_average_unit] ERROR");
      $finish;
   end

endmodule
